// ===== rtl/mfep_pkg.sv =====
// ----------------------------------------------------------------------------
// mfep_pkg
// Shared types, constants and helpers of the MIDI file event parser.
// ----------------------------------------------------------------------------
package mfep_pkg;

	localparam logic [3:0] K_HEADER   = 4'd0;
	localparam logic [3:0] K_BAD_HDR  = 4'd1;
	localparam logic [3:0] K_TEMPO    = 4'd2;
	localparam logic [3:0] K_TIME_SIG = 4'd3;
	localparam logic [3:0] K_NOTE_OFF = 4'd4;
	localparam logic [3:0] K_NOTE_ON  = 4'd5;
	localparam logic [3:0] K_CTRL     = 4'd6;
	localparam logic [3:0] K_BEND     = 4'd7;
	localparam logic [3:0] K_PROGRAM  = 4'd8;
	localparam logic [3:0] K_PRESSURE = 4'd9;
	localparam logic [3:0] K_TRK_END  = 4'd10;

	localparam logic [31:0] ID_MTHD = 32'h4D546864;
	localparam logic [31:0] ID_MTRK = 32'h4D54726B;
	localparam logic [7:0]  META_TEMPO = 8'h51;
	localparam logic [7:0]  META_TSIG  = 8'h58;
	localparam logic [7:0]  META_EOT   = 8'h2F;
	localparam logic [7:0]  ST_META    = 8'hFF;
	localparam logic [7:0]  ST_SYSEX   = 8'hF0;
	localparam logic [7:0]  ST_SYSEX_E = 8'hF7;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] tick;
		logic [3:0]  channel;
		logic [6:0]  data1;
		logic [6:0]  data2;
		logic [23:0] value;
		logic [15:0] visual_track;
		logic        single_track_format;
		logic [15:0] track_total;
		logic        last_of_run;
	} result_t;

	function automatic result_t mk_res(logic [3:0] kind, logic [31:0] tick, logic [3:0] ch,
			logic [6:0] d1, logic [6:0] d2, logic [23:0] val, logic [15:0] vt,
			logic single, logic [15:0] total);
		result_t r;
		r.kind = kind;
		r.tick = tick;
		r.channel = ch;
		r.data1 = d1;
		r.data2 = d2;
		r.value = val;
		r.visual_track = vt;
		r.single_track_format = single;
		r.track_total = total;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	function automatic logic [1:0] data_need(logic [7:0] st);
		return (st[7:4] == 4'hC || st[7:4] == 4'hD) ? 2'd1 : 2'd2;
	endfunction

	function automatic logic chan_emits(logic [7:0] st, logic [7:0] a);
		logic r;
		case (st[7:4]) inside
			4'h8, 4'h9, 4'hE, 4'hC, 4'hD: r = 1'b1;
			4'hB:                         r = (a != 8'd120 && a != 8'd121 && a != 8'd123);
			default:                      r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic result_t chan_res(logic [7:0] st, logic [7:0] a, logic [7:0] b,
			logic fz, logic [15:0] ci, logic [31:0] tick);
		logic [15:0] vt;
		logic [3:0]  k;
		logic [6:0]  d2;
		vt = fz ? {12'd0, st[3:0]} : ci;
		k = K_NOTE_OFF;
		d2 = b[6:0];
		case (st[7:4])
			4'h8: begin k = K_NOTE_OFF; d2 = 7'd0; end
			4'h9: begin
				if (b == 8'd0) begin
					k = K_NOTE_OFF;
					d2 = 7'd0;
				end else begin
					k = K_NOTE_ON;
				end
			end
			4'hB: k = K_CTRL;
			4'hE: k = K_BEND;
			4'hC: begin k = K_PROGRAM; d2 = 7'd0; end
			4'hD: begin k = K_PRESSURE; d2 = 7'd0; end
			default: k = K_NOTE_OFF;
		endcase
		return mk_res(k, tick, st[3:0], a[6:0], d2, 24'd0, vt, 1'b0, 16'd0);
	endfunction

endpackage

// ===== rtl/mfep_byte_if.sv =====
// ----------------------------------------------------------------------------
// mfep_byte_if
// Byte channel of the parser: one file byte and its start-of-file mark.
// ----------------------------------------------------------------------------
interface mfep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_start;

	modport source (output valid, output data_byte, output file_start, input ready);
	modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

// ===== rtl/mfep_event_if.sv =====
// ----------------------------------------------------------------------------
// mfep_event_if
// Event channel of the parser: one parsed result item.
// ----------------------------------------------------------------------------
interface mfep_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [31:0] tick;
	logic [3:0]  channel;
	logic [6:0]  data1;
	logic [6:0]  data2;
	logic [23:0] value;
	logic [15:0] visual_track;
	logic        single_track_format;
	logic [15:0] track_total;
	logic        last_of_run;

	modport source (output valid, output kind, output tick, output channel, output data1,
		output data2, output value, output visual_track, output single_track_format,
		output track_total, output last_of_run, input ready);
	modport sink (input valid, input kind, input tick, input channel, input data1,
		input data2, input value, input visual_track, input single_track_format,
		input track_total, input last_of_run, output ready);
endinterface

// ===== rtl/mfep_core.sv =====
// ----------------------------------------------------------------------------
// mfep_core
// Parse state and per-byte decode; gives up to two results per byte.
// ----------------------------------------------------------------------------
module mfep_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  logic [7:0]          byte_s1,
	input  logic                start_s1,
	output logic [1:0]          res_cnt,
	output mfep_pkg::result_t   res0,
	output mfep_pkg::result_t   res1
);
	import mfep_pkg::*;

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_HDR    = 4'd1;
	localparam logic [3:0] PH_HSKIP  = 4'd2;
	localparam logic [3:0] PH_CHDR   = 4'd3;
	localparam logic [3:0] PH_CSKIP  = 4'd4;
	localparam logic [3:0] PH_DELTA  = 4'd5;
	localparam logic [3:0] PH_STATUS = 4'd6;
	localparam logic [3:0] PH_CDATA  = 4'd7;
	localparam logic [3:0] PH_MTYPE  = 4'd8;
	localparam logic [3:0] PH_MLEN   = 4'd9;
	localparam logic [3:0] PH_MDATA  = 4'd10;
	localparam logic [3:0] PH_PSKIP  = 4'd11;
	localparam logic [3:0] PH_SLEN   = 4'd12;
	localparam logic [3:0] PH_ONE    = 4'd13;
	localparam logic [3:0] PH_DONE   = 4'd14;
	localparam logic [3:0] PH_DEAD   = 4'd15;

	logic [3:0]  ph_q, ph;
	logic [3:0]  fc_q, fc;
	logic [31:0] ha_q, ha;
	logic [31:0] cbl_q, cbl;
	logic [31:0] sk_q, sk;
	logic [31:0] tt_q, tt;
	logic [31:0] va_q, va;
	logic [2:0]  vb_q, vb;
	logic [7:0]  rs_q, rs;
	logic [7:0]  cs_q, cs;
	logic [7:0]  h0_q, h0;
	logic [7:0]  h1_q, h1;
	logic [7:0]  mk_q, mk;
	logic [15:0] ci_q, ci;
	logic [15:0] ct_q, ct;
	logic        fz_q, fz;
	logic [5:0]  sn_q, sn;
	logic [5:0]  sd_q, sd;

	result_t     res [2];
	logic [1:0]  cnt;
	logic        end_req;
	logic        enter_req;
	logic        first;
	logic        vdone;
	logic [7:0]  b;
	logic [7:0]  st;
	logic [7:0]  nn;
	logic [7:0]  dd;

	always_comb begin
		ph = ph_q; fc = fc_q; ha = ha_q; cbl = cbl_q; sk = sk_q; tt = tt_q;
		va = va_q; vb = vb_q; rs = rs_q; cs = cs_q; h0 = h0_q; h1 = h1_q;
		mk = mk_q; ci = ci_q; ct = ct_q; fz = fz_q; sn = sn_q; sd = sd_q;
		res[0] = '0;
		res[1] = '0;
		cnt = 2'd0;
		end_req = 1'b0;
		enter_req = 1'b0;
		first = 1'b0;
		vdone = 1'b0;
		b = byte_s1;
		st = 8'd0;
		nn = 8'd0;
		dd = 8'd0;
		if (valid_s1) begin
			if (start_s1) begin
				fc = '0; ha = '0; cbl = '0; sk = '0; tt = '0; va = '0; vb = '0;
				rs = '0; cs = '0; h0 = '0; h1 = '0; mk = '0; ci = '0; ct = '0;
				fz = 1'b0; sn = 6'd4; sd = 6'd4;
				ph = PH_HDR;
			end
			unique case (ph) inside
				PH_HDR: begin
					ha = {ha[23:0], b};
					if (fc == 4'd3 && ha != ID_MTHD) begin
						res[cnt[0]] = mk_res(K_BAD_HDR, '0, '0, '0, '0, '0, '0, 1'b0, '0);
						cnt = cnt + 2'd1;
						ph = PH_DEAD;
					end else begin
						if (fc == 4'd7) sk = ha;
						if (fc == 4'd9) fz = (ha[15:0] == 16'd0);
						if (fc == 4'd11) ct = ha[15:0];
						if (fc == 4'd13) begin
							res[cnt[0]] = mk_res(K_HEADER, '0, '0, '0, '0,
								{9'd0, ha[14:0]}, '0, fz, ct);
							cnt = cnt + 2'd1;
							sk = (sk > 32'd6) ? sk - 32'd6 : 32'd0;
							if (sk != 32'd0) ph = PH_HSKIP;
							else enter_req = 1'b1;
						end else begin
							fc = fc + 4'd1;
						end
					end
				end
				PH_HSKIP: begin
					if (sk != 32'd0) sk = sk - 32'd1;
					if (sk == 32'd0) enter_req = 1'b1;
				end
				PH_CHDR: begin
					if (fc < 4'd4) ha = {ha[23:0], b};
					else cbl = {cbl[23:0], b};
					if (fc < 4'd7) begin
						fc = fc + 4'd1;
					end else if (ha == ID_MTRK) begin
						tt = '0; rs = '0; cs = '0;
						if (cbl == 32'd0) begin
							end_req = 1'b1;
						end else begin
							ph = PH_DELTA; va = '0; vb = '0;
						end
					end else begin
						sk = cbl; cbl = '0;
						if (sk != 32'd0) begin
							ph = PH_CSKIP;
						end else begin
							ci = ci + 16'd1;
							enter_req = 1'b1;
						end
					end
				end
				PH_CSKIP: begin
					if (sk != 32'd0) sk = sk - 32'd1;
					if (sk == 32'd0) begin
						ci = ci + 16'd1;
						enter_req = 1'b1;
					end
				end
				PH_DELTA, PH_STATUS, PH_CDATA, PH_MTYPE, PH_MLEN, PH_MDATA, PH_PSKIP,
				PH_SLEN, PH_ONE: begin
					if (cbl != 32'd0) cbl = cbl - 32'd1;
					unique case (ph)
						PH_DELTA: begin
							va = {va[24:0], b[6:0]};
							vb = vb + 3'd1;
							if (!b[7] || vb >= 3'd4) begin
								tt = tt + va; va = '0; ph = PH_STATUS;
							end
						end
						PH_STATUS: begin
							first = !b[7];
							if (b[7]) begin
								if (b < ST_SYSEX) rs = b;
								st = b;
							end else begin
								st = rs;
							end
							cs = st;
							h0 = first ? b : 8'd0;
							h1 = 8'd0;
							fc = first ? 4'd1 : 4'd0;
							if (st == ST_META) begin
								ph = PH_MTYPE;
							end else if (st == ST_SYSEX || st == ST_SYSEX_E) begin
								ph = PH_SLEN; va = '0; vb = '0;
							end else if (!st[7] || st[7:4] == 4'hF) begin
								if (first) begin
									ph = PH_DELTA; va = '0; vb = '0;
								end else begin
									ph = PH_ONE;
								end
							end else if (fc >= {2'd0, data_need(st)}) begin
								if (chan_emits(cs, h0)) begin
									res[cnt[0]] = chan_res(cs, h0, h1, fz, ci, tt);
									cnt = cnt + 2'd1;
								end
								ph = PH_DELTA; va = '0; vb = '0;
							end else begin
								ph = PH_CDATA;
							end
						end
						PH_CDATA: begin
							if (fc[0]) h1 = b;
							else h0 = b;
							fc = fc + 4'd1;
							if (fc >= {2'd0, data_need(cs)}) begin
								if (chan_emits(cs, h0)) begin
									res[cnt[0]] = chan_res(cs, h0, h1, fz, ci, tt);
									cnt = cnt + 2'd1;
								end
								ph = PH_DELTA; va = '0; vb = '0;
							end
						end
						PH_MTYPE: begin
							mk = b; va = '0; vb = '0; ph = PH_MLEN;
						end
						PH_MLEN: begin
							va = {va[24:0], b[6:0]};
							vb = vb + 3'd1;
							if (!b[7] || vb >= 3'd4) begin
								if ((mk == META_TEMPO && va == 32'd3 && cbl >= 32'd3) ||
										(mk == META_TSIG && va == 32'd4 && cbl >= 32'd4)) begin
									ph = PH_MDATA; fc = '0; ha = '0;
								end else if (mk == META_EOT) begin
									end_req = 1'b1;
								end else if (va != 32'd0 && cbl >= va) begin
									sk = va; ph = PH_PSKIP;
								end else begin
									ph = PH_DELTA; va = '0; vb = '0;
								end
							end
						end
						PH_MDATA: begin
							fc = fc + 4'd1;
							if (mk == META_TEMPO) begin
								ha = {ha[23:0], b};
								if (fc >= 4'd3) begin
									res[cnt[0]] = mk_res(K_TEMPO, tt, '0, '0, '0, ha[23:0],
										'0, 1'b0, '0);
									cnt = cnt + 2'd1;
									ph = PH_DELTA; va = '0; vb = '0;
								end
							end else if (fc == 4'd1) begin
								h0 = b;
							end else if (fc == 4'd2) begin
								h1 = b;
							end else if (fc >= 4'd4) begin
								nn = h0;
								dd = h1;
								if (nn < 8'd1) nn = 8'd1;
								if (nn > 8'd32) nn = 8'd32;
								if (dd > 8'd5) dd = 8'd5;
								if (sn == 6'd4 && sd == 6'd4) begin
									sn = nn[5:0];
									sd = 6'd1 << dd[2:0];
									if (!(sn == 6'd4 && sd == 6'd4)) begin
										res[cnt[0]] = mk_res(K_TIME_SIG, tt, '0, {1'b0, sn},
											{1'b0, sd}, '0, '0, 1'b0, '0);
										cnt = cnt + 2'd1;
									end
								end
								ph = PH_DELTA; va = '0; vb = '0;
							end
						end
						PH_PSKIP: begin
							if (sk != 32'd0) sk = sk - 32'd1;
							if (sk == 32'd0) begin
								ph = PH_DELTA; va = '0; vb = '0;
							end
						end
						PH_SLEN: begin
							va = {va[24:0], b[6:0]};
							vb = vb + 3'd1;
							if (!b[7] || vb >= 3'd4) begin
								if (va != 32'd0 && cbl >= va) begin
									sk = va; ph = PH_PSKIP;
								end else begin
									ph = PH_DELTA; va = '0; vb = '0;
								end
							end
						end
						default: begin
							ph = PH_DELTA; va = '0; vb = '0;
						end
					endcase
					if (!end_req && ph >= PH_DELTA && ph <= PH_ONE && cbl == 32'd0) begin
						if (ph == PH_DELTA) tt = tt + va;
						if (ph == PH_CDATA && chan_emits(cs, h0)) begin
							res[cnt[0]] = chan_res(cs, h0, h1, fz, ci, tt);
							cnt = cnt + 2'd1;
						end
						end_req = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (end_req) begin
				res[cnt[0]] = mk_res(K_TRK_END, tt, '0, '0, '0, '0, ci, 1'b0, '0);
				cnt = cnt + 2'd1;
				if (cbl != 32'd0) begin
					sk = cbl; cbl = '0; ph = PH_CSKIP;
				end else begin
					ci = ci + 16'd1;
					enter_req = 1'b1;
				end
			end
			if (enter_req) begin
				if (ci >= ct) begin
					ph = PH_DONE;
				end else begin
					ph = PH_CHDR; fc = '0; ha = '0; cbl = '0;
				end
			end
			if (cnt == 2'd2) res[1].last_of_run = 1'b1;
			else if (cnt == 2'd1) res[0].last_of_run = 1'b1;
		end
	end

	assign res_cnt = cnt;
	assign res0 = res[0];
	assign res1 = res[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE; fc_q <= '0; ha_q <= '0; cbl_q <= '0; sk_q <= '0;
			tt_q <= '0; va_q <= '0; vb_q <= '0; rs_q <= '0; cs_q <= '0;
			h0_q <= '0; h1_q <= '0; mk_q <= '0; ci_q <= '0; ct_q <= '0;
			fz_q <= 1'b0; sn_q <= 6'd4; sd_q <= 6'd4;
		end else begin
			ph_q <= ph; fc_q <= fc; ha_q <= ha; cbl_q <= cbl; sk_q <= sk;
			tt_q <= tt; va_q <= va; vb_q <= vb; rs_q <= rs; cs_q <= cs;
			h0_q <= h0; h1_q <= h1; mk_q <= mk; ci_q <= ci; ct_q <= ct;
			fz_q <= fz; sn_q <= sn; sd_q <= sd;
		end
	end

endmodule

// ===== rtl/mfep_fifo.sv =====
// ----------------------------------------------------------------------------
// mfep_fifo
// Result queue: takes up to two items per cycle, gives one.
// ----------------------------------------------------------------------------
module mfep_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [1:0]                push_cnt,
	input  mfep_pkg::result_t         push0,
	input  mfep_pkg::result_t         push1,
	input  logic                      pop,
	output logic                      not_empty,
	output mfep_pkg::result_t         head,
	output logic [mfep_pkg::FIFO_AW:0] count
);
	import mfep_pkg::*;

	result_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_pop;

	assign not_empty = (count_q != '0);
	assign head = mem_q[rd_q];
	assign count = count_q;
	assign do_pop = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_q] <= push0;
		if (push_cnt == 2'd2) mem_q[wr_q + FIFO_AW'(1)] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + FIFO_AW'(push_cnt);
			if (do_pop) rd_q <= rd_q + FIFO_AW'(1);
			count_q <= count_q + (FIFO_AW + 1)'(push_cnt) - (FIFO_AW + 1)'(do_pop);
		end
	end

endmodule

// ===== rtl/midi_file_event_parser.sv =====
// ----------------------------------------------------------------------------
// midi_file_event_parser
// Standard MIDI file parser: file bytes in, header, bad-header, tempo, time
// signature, channel and track-end events out.
//
// byte_in carries one file byte per item with file_start marking the first
// byte of a file; event_out carries parsed events, with last_of_run set on
// the final event caused by one byte.
// Each accepted byte is registered, decoded in the following cycle against
// the parse state, and its zero, one or two events are written to an
// eight-entry queue that drives event_out. One byte is taken per cycle
// while the queue has room for the events of the byte in flight and the
// next one; a stall on event_out lets the queue grow past four entries and
// then drops byte_in.ready.
// Reset clears the parse state to waiting for a file start and empties the
// queue.
// ----------------------------------------------------------------------------
module midi_file_event_parser (
	input  logic         clk,
	input  logic         arst_n,
	mfep_byte_if.sink    byte_in,
	mfep_event_if.source event_out
);
	import mfep_pkg::*;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               start_s1;
	logic [1:0]         res_cnt;
	result_t            res0;
	result_t            res1;
	result_t            head;
	logic               not_empty;
	logic [FIFO_AW:0]   count;

	assign byte_in.ready = (count <= (FIFO_AW + 1)'(FIFO_DEPTH - 4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= byte_in.valid && byte_in.ready;
		end
	end

	always_ff @(posedge clk) begin
		byte_s1 <= byte_in.data_byte;
		start_s1 <= byte_in.file_start;
	end

	mfep_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.start_s1 (start_s1),
		.res_cnt  (res_cnt),
		.res0     (res0),
		.res1     (res1)
	);

	mfep_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (res_cnt),
		.push0     (res0),
		.push1     (res1),
		.pop       (event_out.ready),
		.not_empty (not_empty),
		.head      (head),
		.count     (count)
	);

	assign event_out.valid = not_empty;
	assign event_out.kind = head.kind;
	assign event_out.tick = head.tick;
	assign event_out.channel = head.channel;
	assign event_out.data1 = head.data1;
	assign event_out.data2 = head.data2;
	assign event_out.value = head.value;
	assign event_out.visual_track = head.visual_track;
	assign event_out.single_track_format = head.single_track_format;
	assign event_out.track_total = head.track_total;
	assign event_out.last_of_run = head.last_of_run;

endmodule
